### design/smps_pkg.sv
// Package for the segment mean block: sizes, item kinds and helpers.
// No dependencies.
package smps_pkg;
  localparam int MaxFrames = 1024;
  localparam int MaxDims   = 32;
  localparam int FrameW    = $clog2(MaxFrames + 1);
  localparam int RowW      = $clog2(MaxFrames);
  localparam int DimW      = $clog2(MaxDims);
  localparam int AddrW     = RowW + DimW;
  localparam int SumW      = 32;
  localparam int DivW      = SumW + 1;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic [1:0] REG_DIMS = 2'd0;
endpackage

### design/smps_div.sv
// Iterative signed divider: 33-bit dividend over 11-bit duration, saturated to a signed 16-bit integer (Q15.0).
// Uses smps_pkg.
module smps_div
  import smps_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [DivW-1:0]  dividend,
  input  logic [FrameW-1:0]       divisor,
  output logic                    done,
  output logic signed [15:0]      quot
);
  logic [DivW-1:0]   rem_r, rem_nxt, q_r, q_nxt;
  logic [FrameW-1:0] dvs_r;
  logic              neg_r;
  logic [5:0]        cnt_r;
  logic              busy_r, done_r;
  logic [DivW:0]     trial;
  logic signed [DivW:0] sq;

  always_comb begin
    trial   = {rem_r, q_r[DivW-1]} - {{(DivW+1-FrameW){1'b0}}, dvs_r};
    rem_nxt = trial[DivW] ? {rem_r[DivW-2:0], q_r[DivW-1]} : trial[DivW-1:0];
    q_nxt   = {q_r[DivW-2:0], ~trial[DivW]};
    sq      = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    if (sq > 34'sd32767) quot = 16'sh7fff;
    else if (sq < -34'sd32768) quot = 16'sh8000;
    else quot = sq[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(DivW);
        rem_r  <= '0;
        q_r    <= dividend[DivW-1] ? DivW'(-dividend) : dividend;
        neg_r  <= dividend[DivW-1];
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
  assign done = done_r;
endmodule

### design/segment_mean_prefix_sum.sv
// Segment mean over prefix sums: loads build prefix rows in a 32K x 32 store,
// queries read two rows per dimension and divide. One load or clear item per
// cycle while no query is running. Each dimension of a query goes through two
// store reads (end row, then start row), a state that launches the divider
// and the 33 steps of the bit-serial divider; all input items are held off
// meanwhile. The last result waits in the output register while the next item
// is accepted; a result still waiting holds the next divider launch.
// The store has no clearing pass; reading an entry never written is undefined.
module segment_mean_prefix_sum
  import smps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [15:0] in_sample,
  input  logic [10:0]        in_seg_start,
  input  logic [10:0]        in_seg_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_mean_value,
  output logic [4:0]         out_dim_index,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  typedef enum logic [2:0] {ST_IDLE, ST_RD_E, ST_RD_S, ST_WAIT, ST_DIV} state_t;
  state_t state_r;

  logic [SumW-1:0]   mem [MaxFrames*MaxDims];
  logic [SumW-1:0]   rdata_r;
  logic [SumW-1:0]   run_r [MaxDims];
  logic [5:0]        dims_r;
  logic [FrameW-1:0] frames_r;
  logic [DimW:0]     elem_r;
  logic [RowW-1:0]   s_row_r, e_row_r;
  logic              s_zero_r;
  logic [FrameW-1:0] dur_r;
  logic [DimW-1:0]   dim_r;
  logic [SumW-1:0]   pe_r;
  logic              div_start_r;
  logic signed [DivW-1:0] diff;
  logic              div_done;
  logic signed [15:0] div_q;
  logic [5:0]        eff;
  logic              acc;
  logic              last_dim;
  logic [FrameW-1:0] s_cl, e_cl;
  logic [SumW-1:0]   sum_new;

  assign pready = 1'b1;
  assign prdata = {26'd0, dims_r};
  assign eff = (dims_r == 6'd0) ? 6'd1 : (dims_r > 6'(MaxDims)) ? 6'(MaxDims) : dims_r;
  assign in_ready = (state_r == ST_IDLE);
  assign acc = in_valid && in_ready;
  assign last_dim = (6'(dim_r) + 6'd1 == eff);
  assign s_cl = (FrameW'(in_seg_start) > frames_r - 1'b1) ? frames_r - 1'b1
                                                          : FrameW'(in_seg_start);
  assign e_cl = (FrameW'(in_seg_end) > frames_r) ? frames_r : FrameW'(in_seg_end);
  assign sum_new = run_r[elem_r[DimW-1:0]] + {{(SumW-16){in_sample[15]}}, in_sample};
  assign diff = $signed({pe_r[SumW-1], pe_r}) -
                (s_zero_r ? '0 : $signed({rdata_r[SumW-1], rdata_r}));

  smps_div u_div (
    .clk, .rst_n, .start(div_start_r), .dividend(diff), .divisor(dur_r),
    .done(div_done), .quot(div_q)
  );

  always_ff @(posedge clk) begin
    if (acc && in_kind == KIND_LOAD && frames_r < FrameW'(MaxFrames) && !elem_r[DimW])
      mem[{frames_r[RowW-1:0], elem_r[DimW-1:0]}] <= sum_new;
    if (state_r == ST_RD_E)
      rdata_r <= mem[{e_row_r, dim_r}];
    else if (state_r == ST_RD_S)
      rdata_r <= mem[{s_row_r, dim_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dims_r      <= 6'd32;
      frames_r    <= '0;
      elem_r      <= '0;
      out_valid   <= 1'b0;
      div_start_r <= 1'b0;
      for (int i = 0; i < MaxDims; i++) run_r[i] <= '0;
    end else begin
      div_start_r <= 1'b0;
      if (psel && penable && pwrite && paddr[2] == REG_DIMS[0]) dims_r <= pwdata[5:0];
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (acc) begin
            unique case (kind_t'(in_kind))
              KIND_LOAD: begin
                if (frames_r < FrameW'(MaxFrames) && !elem_r[DimW]) begin
                  run_r[elem_r[DimW-1:0]] <= sum_new;
                  if (elem_r + 1'b1 >= eff) begin
                    elem_r   <= '0;
                    frames_r <= frames_r + 1'b1;
                  end else elem_r <= elem_r + 1'b1;
                end
              end
              KIND_CLEAR: begin
                for (int i = 0; i < MaxDims; i++) run_r[i] <= '0;
                frames_r <= '0;
                elem_r   <= '0;
              end
              KIND_QUERY: begin
                if (frames_r != '0 && s_cl < e_cl) begin
                  e_row_r  <= RowW'(e_cl - 1'b1);
                  s_row_r  <= RowW'(s_cl - 1'b1);
                  s_zero_r <= (s_cl == '0);
                  dur_r    <= e_cl - s_cl;
                  dim_r    <= '0;
                  state_r  <= ST_RD_E;
                end
              end
              default: ;
            endcase
          end
        end
        ST_RD_E: state_r <= ST_RD_S;
        ST_RD_S: begin
          pe_r    <= rdata_r;
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          // the output register must be free by the time the quotient lands
          if (!out_valid || out_ready) begin
            div_start_r <= 1'b1;
            state_r     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            out_valid      <= 1'b1;
            out_mean_value <= div_q;
            out_dim_index  <= 5'(dim_r);
            out_last       <= last_dim;
            if (last_dim) state_r <= ST_IDLE;
            else begin
              dim_r   <= dim_r + 1'b1;
              state_r <= ST_RD_E;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule
